/* hw/rtl/fczs_pkg.sv */
// Shared types, constants and codes for the force curve Z sweep sequencer.
package fczs_pkg;

    localparam int RAMP_STEPS_DEF = 20;
    localparam int MAX_POINTS_DEF = 1000;
    localparam int ZW  = 16;
    localparam int CW  = 10;
    localparam int DW  = 15;

    // result kinds
    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_DAC      = 3'd1,
        K_SAMPLE   = 3'd2,
        K_DELAY    = 3'd3,
        K_LOOP_OFF = 3'd4,
        K_LOOP_ON  = 3'd5
    } kind_t;

    // input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // config register indexes
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    // interpolation segments
    localparam logic [1:0] SEG_RAMP_IN  = 2'd0;
    localparam logic [1:0] SEG_DOWN     = 2'd1;
    localparam logic [1:0] SEG_UP       = 2'd2;
    localparam logic [1:0] SEG_RAMP_OUT = 2'd3;

    // value source select for one result word
    typedef enum logic [2:0] {
        SRC_COUNT, SRC_START, SRC_END, SRC_DELAY, SRC_ZERO,
        SRC_DAC, SRC_ADC, SRC_SAVED_DELAY
    } src_t;

    // controller -> datapath commands
    typedef struct packed {
        logic        capture;    // latch registers and present Z/delay
        logic        calc;       // start one interpolation
        logic [1:0]  seg;        // segment, one of the SEG_ codes
        logic        adc_load;   // latch the sample
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic        busy;
    } dp_sts_t;

endpackage

/* hw/rtl/force_curve_z_sweep_sequencer.sv */
// Top level of the force curve Z sweep sequencer: config registers, controller, datapath.
//
//  channel  | handshake                | payload
//  s_       | s_valid / s_ready        | s_cmd, s_current_z, s_current_loop_delay, s_adc_value
//  m_       | m_valid / m_ready        | m_kind, m_value, m_last
//  cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
// One item at a time; s_ready stays low until every result of the item is loaded.
// A DAC point follows its item in these steps: a start cycle, the serial divider at one
// product bit a cycle (CNT_W+18 bits), a finish cycle, a hand-over cycle and the output
// load; the next item can be taken in the cycle after the load.
// A start sends four headers and loop off one a cycle unless stalled, then its first point.
// Synchronous active-low reset clears phase, counters and the output register.
// A stall on m_ready holds the controller at its next output load.
module force_curve_z_sweep_sequencer #(
    parameter int RAMP_STEPS = fczs_pkg::RAMP_STEPS_DEF,
    parameter int MAX_POINTS = fczs_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic signed [15:0]  s_current_z,
    input  logic signed [15:0]  s_current_loop_delay,
    input  logic signed [15:0]  s_adc_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [15:0]         m_value,
    output logic                m_last,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import fczs_pkg::*;

    // index counter must hold both the point count and the ramp length
    localparam int PTS_W  = $clog2(MAX_POINTS + 1);
    localparam int RAMP_W = $clog2(RAMP_STEPS + 1);
    localparam int CNT_W  = (PTS_W > RAMP_W) ? PTS_W : RAMP_W;

    logic signed [15:0] start_reg, end_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [14:0]        delay_reg;
    dp_cmd_t            dcmd;
    dp_sts_t            dsts;
    logic [CNT_W-1:0]   index, cap_count;
    src_t               src;
    logic [15:0]        word;
    logic [9:0]         cnt_in;

    // config registers with saturation
    assign cnt_in = cfg_data[9:0];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0; end_reg <= '0;
            count_reg <= CNT_W'(2); delay_reg <= 15'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START: start_reg <= cfg_data;
                REG_END:   end_reg   <= cfg_data;
                REG_COUNT: begin
                    if (cnt_in < 10'd2) count_reg <= CNT_W'(2);
                    else if (32'(cnt_in) > MAX_POINTS) count_reg <= CNT_W'(MAX_POINTS);
                    else count_reg <= CNT_W'(cnt_in);
                end
                REG_DELAY: delay_reg <= (cfg_data[14:0] < 15'd2) ? 15'd2 : cfg_data[14:0];
                default: ;
            endcase
        end
    end

    fczs_ctrl #(.RAMP_STEPS(RAMP_STEPS), .CNT_W(CNT_W)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd,
        .m_valid, .m_ready, .m_kind, .m_value, .m_last,
        .dcmd, .dsts, .index, .src, .cap_count, .word
    );

    fczs_datapath #(.RAMP_STEPS(RAMP_STEPS), .CNT_W(CNT_W)) u_dp (
        .aclk, .aresetn, .cmd(dcmd), .sts(dsts), .index, .src,
        .cfg_start(start_reg), .cfg_end(end_reg), .cfg_count(count_reg),
        .cfg_delay(delay_reg), .in_z(s_current_z), .in_delay(s_current_loop_delay),
        .in_adc(s_adc_value), .cap_count, .word
    );
endmodule

/* hw/rtl/fczs_datapath.sv */
// Datapath: captured settings, interpolation with a serial divider, result word select.
module fczs_datapath #(
    parameter int RAMP_STEPS = fczs_pkg::RAMP_STEPS_DEF,
    parameter int CNT_W      = fczs_pkg::CW
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fczs_pkg::dp_cmd_t       cmd,
    output fczs_pkg::dp_sts_t       sts,
    input  logic [CNT_W-1:0]        index,
    input  fczs_pkg::src_t          src,
    input  logic signed [15:0]      cfg_start,
    input  logic signed [15:0]      cfg_end,
    input  logic [CNT_W-1:0]        cfg_count,
    input  logic [14:0]             cfg_delay,
    input  logic signed [15:0]      in_z,
    input  logic signed [15:0]      in_delay,
    input  logic signed [15:0]      in_adc,
    output logic [CNT_W-1:0]        cap_count,
    output logic [15:0]             word
);
    import fczs_pkg::*;

    localparam int PW = CNT_W + 18;      // product width
    localparam int SW = $clog2(PW + 1);

    logic signed [15:0] start_reg, end_reg, savz_reg, savd_reg, adc_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [14:0]        delay_reg;
    logic signed [15:0] dac_z_reg;

    logic signed [15:0] a_sel, b_sel;
    logic [CNT_W-1:0]   div_sel;

    // divider state
    logic               busy_reg;
    logic [SW-1:0]      bit_reg;
    logic [PW-1:0]      num_reg, quo_reg;
    logic [CNT_W:0]     rem_reg;
    logic [CNT_W-1:0]   den_reg;
    logic               neg_reg;
    logic signed [15:0] base_reg;

    logic signed [16:0] diff;
    logic signed [PW-1:0] prod;
    logic [CNT_W:0]     rem_sh;
    logic signed [PW:0] zfull;
    logic [PW-1:0]      q_s;

    // endpoints of the active segment
    always_comb begin
        unique case (cmd.seg)
            SEG_RAMP_IN:  begin a_sel = savz_reg;  b_sel = start_reg; end
            SEG_DOWN:     begin a_sel = start_reg; b_sel = end_reg;   end
            SEG_UP:       begin a_sel = end_reg;   b_sel = start_reg; end
            SEG_RAMP_OUT: begin a_sel = start_reg; b_sel = savz_reg;  end
        endcase
        div_sel = (cmd.seg == SEG_RAMP_IN || cmd.seg == SEG_RAMP_OUT)
                ? CNT_W'(RAMP_STEPS - 1) : count_reg - CNT_W'(1);
        diff = 17'(b_sel) - 17'(a_sel);
        prod = PW'($signed({1'b0, index})) * PW'(diff);
    end

    assign rem_sh = {rem_reg[CNT_W-1:0], num_reg[PW-1]};
    assign q_s    = neg_reg ? (~quo_reg + PW'(1)) : quo_reg;
    assign zfull  = (PW+1)'(base_reg) + (PW+1)'($signed(q_s));

    // capture, sample latch and restoring division one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            count_reg <= CNT_W'(2);
            delay_reg <= 15'd2;
            start_reg <= '0; end_reg <= '0; savz_reg <= '0; savd_reg <= '0;
        end else begin
            if (cmd.capture) begin
                start_reg <= cfg_start; end_reg <= cfg_end;
                count_reg <= cfg_count; delay_reg <= cfg_delay;
                savz_reg <= in_z; savd_reg <= in_delay;
            end
            if (cmd.calc) begin
                busy_reg <= 1'b1;
                bit_reg  <= SW'(PW);
                neg_reg  <= prod[PW-1];
                num_reg  <= prod[PW-1] ? PW'(-prod) : PW'(prod);
                rem_reg  <= '0;
                quo_reg  <= '0;
                den_reg  <= div_sel;
                base_reg <= a_sel;
            end else if (busy_reg) begin
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    if (zfull > (PW+1)'(32767))       dac_z_reg <= 16'sh7fff;
                    else if (zfull < -(PW+1)'(32768)) dac_z_reg <= -16'sh8000;
                    else                              dac_z_reg <= zfull[15:0];
                end else begin
                    bit_reg <= bit_reg - SW'(1);
                    num_reg <= {num_reg[PW-2:0], 1'b0};
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                end
            end
            if (cmd.adc_load) adc_reg <= in_adc;
        end
    end

    // result word mux
    always_comb begin
        unique case (src)
            SRC_COUNT:       word = 16'(count_reg);
            SRC_START:       word = start_reg;
            SRC_END:         word = end_reg;
            SRC_DELAY:       word = {1'b0, delay_reg};
            SRC_ZERO:        word = '0;
            SRC_DAC:         word = {~dac_z_reg[15], dac_z_reg[14:0]};
            SRC_ADC:         word = adc_reg;
            SRC_SAVED_DELAY: word = savd_reg;
            default:         word = '0;
        endcase
    end

    assign sts.busy  = busy_reg | cmd.calc;
    assign cap_count = count_reg;

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !cmd.calc |-> bit_reg <= SW'(PW))
        else $error("divider bit counter out of range");
    a_den_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> den_reg != '0)
        else $error("zero divisor");
    a_rem_lt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !cmd.calc |-> rem_reg < {1'b0, den_reg})
        else $error("remainder not below divisor");
endmodule

/* hw/rtl/fczs_ctrl.sv */
// Controller: event decode, phase sequencing and result emission.
module fczs_ctrl #(
    parameter int RAMP_STEPS = fczs_pkg::RAMP_STEPS_DEF,
    parameter int CNT_W      = fczs_pkg::CW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_kind,
    output logic [15:0]          m_value,
    output logic                 m_last,
    output fczs_pkg::dp_cmd_t    dcmd,
    input  fczs_pkg::dp_sts_t    dsts,
    output logic [CNT_W-1:0]     index,
    output fczs_pkg::src_t       src,
    input  logic [CNT_W-1:0]     cap_count,
    input  logic [15:0]          word
);
    import fczs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_RAMP_IN, PH_WAIT, PH_DOWN, PH_UP, PH_RAMP_OUT
    } phase_t;

    // micro steps of one item; every step that emits waits for a free output
    typedef enum logic [2:0] {
        ST_READY, ST_HDR, ST_CALC, ST_DAC, ST_DELAY, ST_ON, ST_SAMPLE
    } step_t;

    phase_t           phase_reg;
    step_t            step_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [1:0]       seg_reg;
    logic [2:0]       hdr_reg;
    logic             calc_go_reg;
    logic             ovalid_reg, olast_reg;
    kind_t            okind_reg;
    logic [15:0]      oval_reg;
    logic             out_free, out_load, calc_start, accept;
    logic             is_start, is_tick, ramp_more, is_first, is_sample;
    kind_t            kind_c;

    assign out_free = !ovalid_reg || m_ready;
    assign s_ready  = (step_reg == ST_READY);
    assign m_valid  = ovalid_reg;
    assign m_kind   = okind_reg;
    assign m_value  = oval_reg;
    assign m_last   = olast_reg;
    assign index    = idx_reg;

    // event decode
    assign accept    = s_valid && s_ready;
    assign is_start  = (s_cmd == CMD_START) && (phase_reg == PH_IDLE);
    assign is_tick   = (s_cmd == CMD_TICK) &&
                       (phase_reg == PH_RAMP_IN || phase_reg == PH_RAMP_OUT);
    assign ramp_more = (idx_reg < CNT_W'(RAMP_STEPS));
    assign is_first  = (s_cmd == CMD_SAMPLE) && (phase_reg == PH_WAIT);
    assign is_sample = (s_cmd == CMD_SAMPLE) && (phase_reg == PH_DOWN || phase_reg == PH_UP);

    // output load and interpolation start
    assign out_load   = out_free && (step_reg == ST_HDR || step_reg == ST_DAC ||
                                     step_reg == ST_DELAY || step_reg == ST_ON ||
                                     step_reg == ST_SAMPLE);
    assign calc_start = (accept && ((is_tick && ramp_more) || is_first)) ||
                        (out_load && (step_reg == ST_SAMPLE ||
                                      (step_reg == ST_HDR && hdr_reg == 3'd4)));

    assign dcmd.capture  = accept && is_start;
    assign dcmd.adc_load = accept && is_sample;
    assign dcmd.calc     = calc_go_reg;
    assign dcmd.seg      = seg_reg;

    // word source and kind for the current emission
    always_comb begin
        unique case (step_reg)
            ST_HDR: begin
                kind_c = (hdr_reg == 3'd4) ? K_LOOP_OFF : K_HEADER;
                unique case (hdr_reg)
                    3'd0: src = SRC_COUNT;
                    3'd1: src = SRC_START;
                    3'd2: src = SRC_END;
                    3'd3: src = SRC_DELAY;
                    default: src = SRC_ZERO;
                endcase
            end
            ST_DAC: begin
                kind_c = K_DAC; src = SRC_DAC;
            end
            ST_DELAY: begin
                kind_c = K_DELAY;
                src = (phase_reg == PH_RAMP_IN) ? SRC_DELAY : SRC_SAVED_DELAY;
            end
            ST_ON: begin
                kind_c = K_LOOP_ON; src = SRC_ZERO;
            end
            ST_SAMPLE: begin
                kind_c = K_SAMPLE; src = SRC_ADC;
            end
            default: begin
                kind_c = K_HEADER; src = SRC_ZERO;
            end
        endcase
    end

    // phase, steps and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; step_reg <= ST_READY; idx_reg <= '0;
            seg_reg <= SEG_RAMP_IN; hdr_reg <= '0; calc_go_reg <= 1'b0;
            ovalid_reg <= 1'b0; olast_reg <= 1'b0;
            okind_reg <= K_HEADER; oval_reg <= '0;
        end else begin
            ovalid_reg  <= out_load || (ovalid_reg && !m_ready);
            calc_go_reg <= calc_start;
            if (out_load) begin
                okind_reg <= kind_c;
                oval_reg  <= word;
                olast_reg <= (step_reg == ST_ON);
            end
            unique case (step_reg)
                ST_READY: begin
                    if (accept) begin
                        unique if (is_start) begin
                            hdr_reg <= '0; step_reg <= ST_HDR;
                        end else if (is_tick) begin
                            step_reg <= ramp_more ? ST_CALC : ST_DELAY;
                        end else if (is_first) begin
                            idx_reg <= '0; seg_reg <= SEG_DOWN; phase_reg <= PH_DOWN;
                            step_reg <= ST_CALC;
                        end else if (is_sample) begin
                            step_reg <= ST_SAMPLE;
                        end else begin
                            step_reg <= ST_READY;
                        end
                    end
                end
                ST_HDR: begin
                    if (out_load) begin
                        if (hdr_reg == 3'd4) begin
                            idx_reg <= '0; seg_reg <= SEG_RAMP_IN; phase_reg <= PH_RAMP_IN;
                            step_reg <= ST_CALC;
                        end else begin
                            hdr_reg <= hdr_reg + 3'd1;
                        end
                    end
                end
                ST_CALC: begin
                    if (!dsts.busy) step_reg <= ST_DAC;
                end
                ST_DAC: begin
                    if (out_load) begin
                        if (phase_reg == PH_RAMP_IN || phase_reg == PH_RAMP_OUT)
                            idx_reg <= idx_reg + CNT_W'(1);
                        step_reg <= ST_READY;
                    end
                end
                ST_DELAY: begin
                    if (out_load) begin
                        idx_reg <= '0;
                        if (phase_reg == PH_RAMP_IN) begin
                            phase_reg <= PH_WAIT; step_reg <= ST_READY;
                        end else begin
                            step_reg <= ST_ON;
                        end
                    end
                end
                ST_ON: begin
                    if (out_load) begin
                        phase_reg <= PH_IDLE; step_reg <= ST_READY;
                    end
                end
                ST_SAMPLE: begin
                    if (out_load) begin
                        step_reg <= ST_CALC;
                        if (idx_reg + CNT_W'(1) < cap_count) begin
                            idx_reg <= idx_reg + CNT_W'(1);
                        end else if (phase_reg == PH_DOWN) begin
                            idx_reg <= '0; seg_reg <= SEG_UP; phase_reg <= PH_UP;
                        end else begin
                            idx_reg <= '0; seg_reg <= SEG_RAMP_OUT; phase_reg <= PH_RAMP_OUT;
                        end
                    end
                end
                default: step_reg <= ST_READY;
            endcase
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value) &&
                                $stable(m_last))
        else $error("result changed while waiting");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> phase_reg == PH_IDLE)
        else $error("last outside end of sequence");
    a_calc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        calc_go_reg |-> step_reg == ST_CALC)
        else $error("calc without wait step");
endmodule

/* tb/force_curve_z_sweep_sequencer_tb.sv */
// Self-checking testbench for the force curve Z sweep sequencer.
module force_curve_z_sweep_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fczs_pkg::*;

    typedef enum int {ST_IDLE, ST_RAMP_IN, ST_WAIT, ST_DOWN, ST_UP, ST_RAMP_OUT} seq_state_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] value;
        logic        last;
    } sweep_word_t;

    localparam int RAMP_N = 20;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Predicts the sweep words and checks them in order
    class sweep_scoreboard;
        sweep_word_t expected_words[$];
        int errors;
        int words_seen;
        int sweeps_done;
        // register copies
        int start_z, end_z, n_points, loop_dly;
        // sequence state
        seq_state_t state;
        int idx, saved_z, saved_dly, cap_start, cap_end, cap_count, cap_delay;

        function new();
            start_z = 0; end_z = 0; n_points = 2; loop_dly = 2;
            state = ST_IDLE; idx = 0; saved_z = 0; saved_dly = 0;
            cap_start = 0; cap_end = 0; cap_count = 2; cap_delay = 2;
            errors = 0; words_seen = 0; sweeps_done = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            int v;
            case (index)
                REG_START: start_z = $signed(data);
                REG_END:   end_z = $signed(data);
                REG_COUNT: begin
                    v = data[9:0];
                    n_points = (v < 2) ? 2 : (v > 1000) ? 1000 : v;
                end
                default: begin
                    v = data[14:0];
                    loop_dly = (v < 2) ? 2 : v;
                end
            endcase
        endfunction

        // truncating interpolation, saturated to 16 bits signed
        function int lerp(int a, int b, int i, int div);
            longint z;
            z = longint'(a) + (longint'(i) * (longint'(b) - longint'(a))) / longint'(div);
            if (z > 32767) z = 32767;
            if (z < -32768) z = -32768;
            return int'(z);
        endfunction

        function void push(kind_t k, int v, logic l);
            sweep_word_t w;
            w.kind = k;
            w.value = v[15:0];
            w.last = l;
            expected_words.push_back(w);
        endfunction

        function void push_dac(int z);
            push(K_DAC, z + 32768, 1'b0);
        endfunction

        function void note_input(logic [1:0] cmd, logic signed [15:0] cz,
                                 logic signed [15:0] cd, logic signed [15:0] adc);
            int div;
            div = cap_count - 1;
            if (cmd == CMD_START) begin
                if (state == ST_IDLE) begin
                    cap_start = start_z; cap_end = end_z;
                    cap_count = n_points; cap_delay = loop_dly;
                    push(K_HEADER, cap_count, 0);
                    push(K_HEADER, cap_start, 0);
                    push(K_HEADER, cap_end, 0);
                    push(K_HEADER, cap_delay, 0);
                    saved_z = cz;
                    saved_dly = cd;
                    push(K_LOOP_OFF, 0, 0);
                    push_dac(lerp(saved_z, cap_start, 0, RAMP_N - 1));
                    idx = 1;
                    state = ST_RAMP_IN;
                end
            end else if (cmd == CMD_TICK) begin
                if (state == ST_RAMP_IN) begin
                    if (idx < RAMP_N) begin
                        push_dac(lerp(saved_z, cap_start, idx, RAMP_N - 1));
                        idx++;
                    end else begin
                        push(K_DELAY, cap_delay, 0);
                        idx = 0;
                        state = ST_WAIT;
                    end
                end else if (state == ST_RAMP_OUT) begin
                    if (idx < RAMP_N) begin
                        push_dac(lerp(cap_start, saved_z, idx, RAMP_N - 1));
                        idx++;
                    end else begin
                        push(K_DELAY, saved_dly, 0);
                        push(K_LOOP_ON, 0, 1);
                        idx = 0;
                        state = ST_IDLE;
                        sweeps_done++;
                    end
                end
            end else if (cmd == CMD_SAMPLE) begin
                if (state == ST_WAIT) begin
                    idx = 0;
                    push_dac(lerp(cap_start, cap_end, 0, div));
                    state = ST_DOWN;
                end else if (state == ST_DOWN) begin
                    push(K_SAMPLE, adc, 0);
                    if (idx + 1 < cap_count) begin
                        idx++;
                        push_dac(lerp(cap_start, cap_end, idx, div));
                    end else begin
                        idx = 0;
                        push_dac(lerp(cap_end, cap_start, 0, div));
                        state = ST_UP;
                    end
                end else if (state == ST_UP) begin
                    push(K_SAMPLE, adc, 0);
                    if (idx + 1 < cap_count) begin
                        idx++;
                        push_dac(lerp(cap_end, cap_start, idx, div));
                    end else begin
                        push_dac(lerp(cap_start, saved_z, 0, RAMP_N - 1));
                        idx = 1;
                        state = ST_RAMP_OUT;
                    end
                end
            end
        endfunction

        function void check_result(logic [2:0] kind, logic [15:0] value, logic last);
            sweep_word_t w;
            words_seen++;
            if (expected_words.size() == 0) begin
                $error("unexpected result: kind %0d value %h last %0b", kind, value, last);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (kind !== w.kind) begin
                $error("kind: expected %0d, got %0d", w.kind, kind);
                errors++;
            end
            if (value !== w.value) begin
                $error("value: expected %h, got %h", w.value, value);
                errors++;
            end
            if (last !== w.last) begin
                $error("last: expected %0b, got %0b", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic signed [15:0] s_current_z;
    logic signed [15:0] s_current_loop_delay;
    logic signed [15:0] s_adc_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_kind;
    logic [15:0]        m_value;
    logic               m_last;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    sweep_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    force_curve_z_sweep_sequencer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_current_z(s_current_z), .s_current_loop_delay(s_current_loop_delay),
        .s_adc_value(s_adc_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_value(m_value), .m_last(m_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // result side: random stalls, check every accepted word
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_kind, m_value, m_last);
    end

    // one input item, with a random gap ahead of it
    task automatic send_item(logic [1:0] cmd, logic signed [15:0] cz,
                             logic signed [15:0] cd, logic signed [15:0] adc);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_current_z <= cz;
        s_current_loop_delay <= cd;
        s_adc_value <= adc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(cmd, cz, cd, adc);
        items_sent++;
    endtask

    // next item of a well-formed sweep, with some noise mixed in
    task automatic send_next();
        logic [1:0] cmd;
        if ($urandom_range(99) < 15)
            cmd = 2'($urandom_range(3));
        else if (sb.state == ST_IDLE)
            cmd = CMD_START;
        else if (sb.state == ST_RAMP_IN || sb.state == ST_RAMP_OUT)
            cmd = CMD_TICK;
        else
            cmd = CMD_SAMPLE;
        send_item(cmd, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic run_sweep();
        send_item(CMD_START, 16'($urandom), 16'($urandom), 16'($urandom));
        while (sb.state != ST_IDLE) send_next();
    endtask

    // hold the sender until everything expected has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2,
                              logic [15:0] d3);
        logic [15:0] vals [4];
        vals = '{d0, d1, d2, d3};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
            sb.write_reg(2'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // run limit
    initial begin
        #20_000_000;
        $display("force_curve_z_sweep_sequencer_tb: done, errors");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd <= CMD_START;
        s_current_z <= '0;
        s_current_loop_delay <= '0;
        s_adc_value <= '0;
        m_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_START;
        cfg_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one sweep per idle pattern; the first is directed
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (p == 0) begin
                // full-scale ramps, count and delay below minimum, stray items
                write_regs(16'h7FFF, 16'h8000, 16'h0000, 16'h0001);
                send_item(CMD_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
                send_item(CMD_TICK, 16'sh0, 16'sh0, 16'sh0);
                send_item(CMD_SAMPLE, 16'sh0, 16'sh0, 16'sh0);
                send_item(CMD_START, 16'sh8000, 16'sh7FFF, 16'sh0);
                send_item(CMD_START, 16'sh7FFF, 16'sh8000, 16'sh0);  // busy: dropped
                while (sb.state != ST_IDLE)
                    send_item(sb.state == ST_RAMP_IN || sb.state == ST_RAMP_OUT
                              ? CMD_TICK : CMD_SAMPLE,
                              16'sh0, 16'sh0, (items_sent & 1) ? 16'sh7FFF : 16'sh8000);
            end else begin
                write_regs(16'($urandom), 16'($urandom), 16'($urandom_range(6)),
                           16'($urandom));
                run_sweep();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("covered %0d items, %0d results, %0d complete sweeps",
                 items_sent, sb.words_seen, sb.sweeps_done);
        $display("idle patterns: none, sender, receiver, both; counts 2 to 6, stray commands");
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("force_curve_z_sweep_sequencer_tb: done, clean");
        else
            $display("force_curve_z_sweep_sequencer_tb: done, errors");
        $finish;
    end
endmodule
